// ===== rtl/core/spfa_pkg.sv =====
// ----------------------------------------------------------------------------
// spfa_pkg
// Shared command codes and flag codes of the prime field arithmetic unit.
// ----------------------------------------------------------------------------
package spfa_pkg;

    // operation selected by one item
    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_SUB    = 3'd1,
        CMD_MUL    = 3'd2,
        CMD_SQUARE = 3'd3,
        CMD_NEGATE = 3'd4,
        CMD_DOUBLE = 3'd5,
        CMD_SMUL   = 3'd6
    } t_cmd;

    // parity-sign code of a result
    typedef enum logic [1:0] {
        SIGN_ZERO = 2'd0,
        SIGN_ODD  = 2'd1,
        SIGN_EVEN = 2'd2
    } t_sign;

endpackage

// ===== rtl/core/spfa_in_if.sv =====
// ----------------------------------------------------------------------------
// spfa_in_if
// Input channel: command, two field elements and a signed multiplier.
// ----------------------------------------------------------------------------
interface spfa_in_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic [2:0]          command;
    logic [W-1:0]        operand_a;
    logic [W-1:0]        operand_b;
    logic signed [W-1:0] signed_factor;

    modport source (output valid, command, operand_a, operand_b, signed_factor,
                    input ready);
    modport sink   (input valid, command, operand_a, operand_b, signed_factor,
                    output ready);
endinterface

// ===== rtl/core/spfa_out_if.sv =====
// ----------------------------------------------------------------------------
// spfa_out_if
// Output channel: reduced result and its flags.
// ----------------------------------------------------------------------------
interface spfa_out_if #(
    parameter int W = 32
);
    logic         valid;
    logic         ready;
    logic [W-1:0] result;
    logic         result_is_zero;
    logic         result_is_one;
    logic [1:0]   result_sign;
    logic         operands_equal;

    modport source (output valid, result, result_is_zero, result_is_one, result_sign,
                    operands_equal, input ready);
    modport sink   (input valid, result, result_is_zero, result_is_one, result_sign,
                    operands_equal, output ready);
endinterface

// ===== rtl/core/spfa_red_stage.sv =====
// ----------------------------------------------------------------------------
// spfa_red_stage
// One bit of the operand reduction: acc = (2*acc + bit) mod m for a, b and
// the factor magnitude, one pipeline register.
// ----------------------------------------------------------------------------
module spfa_red_stage #(
    parameter int W   = 32,
    parameter int BIT = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [W-1:0]      i_modulus,
    input  logic              i_valid,
    input  spfa_pkg::t_cmd    i_cmd,
    input  logic              i_eq,
    input  logic              i_neg,
    input  logic [W-1:0]      i_ra,
    input  logic [W-1:0]      i_rb,
    input  logic [W-1:0]      i_mag,
    input  logic [W-1:0]      i_ua,
    input  logic [W-1:0]      i_ub,
    input  logic [W-1:0]      i_uf,
    output logic              o_valid,
    output spfa_pkg::t_cmd    o_cmd,
    output logic              o_eq,
    output logic              o_neg,
    output logic [W-1:0]      o_ra,
    output logic [W-1:0]      o_rb,
    output logic [W-1:0]      o_mag,
    output logic [W-1:0]      o_ua,
    output logic [W-1:0]      o_ub,
    output logic [W-1:0]      o_uf
);
    import spfa_pkg::*;

    logic         r_valid;
    t_cmd         r_cmd;
    logic         r_eq, r_neg;
    logic [W-1:0] r_ra, r_rb, r_mag, r_ua, r_ub, r_uf;

    // shift in one bit and subtract the modulus once
    function automatic logic [W-1:0] red_step(input logic [W-1:0] acc, input logic b,
                                              input logic [W-1:0] m);
        logic [W:0] s;
        s = {acc, b};
        if (s >= {1'b0, m}) s = s - {1'b0, m};
        return s[W-1:0];
    endfunction

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cmd <= i_cmd;
            r_eq  <= i_eq;
            r_neg <= i_neg;
            r_ra  <= i_ra;
            r_rb  <= i_rb;
            r_mag <= i_mag;
            r_ua  <= red_step(i_ua, i_ra[BIT], i_modulus);
            r_ub  <= red_step(i_ub, i_rb[BIT], i_modulus);
            r_uf  <= red_step(i_uf, i_mag[BIT], i_modulus);
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;
    assign o_eq    = r_eq;
    assign o_neg   = r_neg;
    assign o_ra    = r_ra;
    assign o_rb    = r_rb;
    assign o_mag   = r_mag;
    assign o_ua    = r_ua;
    assign o_ub    = r_ub;
    assign o_uf    = r_uf;
endmodule

// ===== rtl/core/spfa_mul_stage.sv =====
// ----------------------------------------------------------------------------
// spfa_mul_stage
// One bit of the modular shift-and-add multiplier: acc = 2*acc (+ x) mod m,
// one pipeline register.
// ----------------------------------------------------------------------------
module spfa_mul_stage #(
    parameter int W   = 32,
    parameter int BIT = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [W-1:0]      i_modulus,
    input  logic              i_valid,
    input  spfa_pkg::t_cmd    i_cmd,
    input  logic              i_eq,
    input  logic              i_neg,
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_b,
    input  logic [W-1:0]      i_y,
    input  logic [W-1:0]      i_acc,
    output logic              o_valid,
    output spfa_pkg::t_cmd    o_cmd,
    output logic              o_eq,
    output logic              o_neg,
    output logic [W-1:0]      o_a,
    output logic [W-1:0]      o_b,
    output logic [W-1:0]      o_y,
    output logic [W-1:0]      o_acc
);
    import spfa_pkg::*;

    logic         r_valid;
    t_cmd         r_cmd;
    logic         r_eq, r_neg;
    logic [W-1:0] r_a, r_b, r_y, r_acc;
    logic [W-1:0] dbl, n_acc;

    // modular add of two reduced values
    function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                             input logic [W-1:0] m);
        logic [W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) s = s - {1'b0, m};
        return s[W-1:0];
    endfunction

    // double, then add the multiplicand when this bit is set
    always_comb begin
        dbl   = add_mod(i_acc, i_acc, i_modulus);
        n_acc = i_y[BIT] ? add_mod(dbl, i_a, i_modulus) : dbl;
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cmd <= i_cmd;
            r_eq  <= i_eq;
            r_neg <= i_neg;
            r_a   <= i_a;
            r_b   <= i_b;
            r_y   <= i_y;
            r_acc <= n_acc;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;
    assign o_eq    = r_eq;
    assign o_neg   = r_neg;
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_y     = r_y;
    assign o_acc   = r_acc;
endmodule

// ===== rtl/core/small_prime_field_alu_core.sv =====
// ----------------------------------------------------------------------------
// small_prime_field_alu_core
// Pipelined prime field arithmetic unit with a configurable modulus.
// ----------------------------------------------------------------------------
// The unit accepts one item per cycle while the output does not stall and
// returns one result per item, in order. The pipeline is made of two
// bit-serial chains and an output stage: WORD_WIDTH stages reduce
// the operands and the factor magnitude modulo the prime, WORD_WIDTH stages
// form the modular product one multiplier bit per stage, and a last stage
// selects the command result and registers it with its flags. The whole
// pipeline stalls only while a result waits at the output. The modulus may be
// written only while no item is in flight; a modulus below two yields zero.
module small_prime_field_alu_core #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [WORD_WIDTH-1:0] i_cfg_wdata,
    spfa_in_if.sink               i_in,
    spfa_out_if.source            o_out
);
    import spfa_pkg::*;

    localparam int W = WORD_WIDTH;

    logic [W-1:0] r_modulus;
    logic         advance;

    // reduction chain signals
    logic         rv   [0:W];
    t_cmd         rcmd [0:W];
    logic         req  [0:W];
    logic         rneg [0:W];
    logic [W-1:0] rra  [0:W];
    logic [W-1:0] rrb  [0:W];
    logic [W-1:0] rmag [0:W];
    logic [W-1:0] rua  [0:W];
    logic [W-1:0] rub  [0:W];
    logic [W-1:0] ruf  [0:W];

    // multiplier chain signals
    logic         mv   [0:W];
    t_cmd         mcmd [0:W];
    logic         meq  [0:W];
    logic         mneg [0:W];
    logic [W-1:0] ma   [0:W];
    logic [W-1:0] mb   [0:W];
    logic [W-1:0] my   [0:W];
    logic [W-1:0] macc [0:W];

    logic         r_out_valid;
    logic [W-1:0] r_result;
    logic         r_is_zero, r_is_one, r_eq;
    t_sign        r_sign;
    logic [W-1:0] n_result;
    logic [W-1:0] prod;
    logic [W:0]   sum_ab, sum_aa;

    // modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= W'(2);
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_wdata;
        end
    end

    // global pipeline advance
    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = advance;

    // entry of the reduction chain
    always_comb begin
        rv[0]   = i_in.valid;
        rcmd[0] = t_cmd'(i_in.command);
        req[0]  = (i_in.operand_a == i_in.operand_b);
        rneg[0] = i_in.signed_factor[W-1];
        rra[0]  = i_in.operand_a;
        rrb[0]  = i_in.operand_b;
        rmag[0] = i_in.signed_factor[W-1] ? (~i_in.signed_factor + W'(1))
                                          : i_in.signed_factor;
        rua[0]  = '0;
        rub[0]  = '0;
        ruf[0]  = '0;
    end

    // operand reduction, most significant bit first
    for (genvar k = 0; k < W; k++) begin : g_red
        spfa_red_stage #(.W(W), .BIT(W-1-k)) u_red (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(advance), .i_modulus(r_modulus),
            .i_valid(rv[k]), .i_cmd(rcmd[k]), .i_eq(req[k]), .i_neg(rneg[k]),
            .i_ra(rra[k]), .i_rb(rrb[k]), .i_mag(rmag[k]),
            .i_ua(rua[k]), .i_ub(rub[k]), .i_uf(ruf[k]),
            .o_valid(rv[k+1]), .o_cmd(rcmd[k+1]), .o_eq(req[k+1]), .o_neg(rneg[k+1]),
            .o_ra(rra[k+1]), .o_rb(rrb[k+1]), .o_mag(rmag[k+1]),
            .o_ua(rua[k+1]), .o_ub(rub[k+1]), .o_uf(ruf[k+1])
        );
    end

    // entry of the multiplier chain: pick the multiplier per command
    always_comb begin
        mv[0]   = rv[W];
        mcmd[0] = rcmd[W];
        meq[0]  = req[W];
        mneg[0] = rneg[W];
        ma[0]   = rua[W];
        mb[0]   = rub[W];
        macc[0] = '0;
        case (rcmd[W])
            CMD_SQUARE: my[0] = rua[W];
            CMD_SMUL:   my[0] = ruf[W];
            default:    my[0] = rub[W];
        endcase
    end

    // modular product, most significant multiplier bit first
    for (genvar k = 0; k < W; k++) begin : g_mul
        spfa_mul_stage #(.W(W), .BIT(W-1-k)) u_mul (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(advance), .i_modulus(r_modulus),
            .i_valid(mv[k]), .i_cmd(mcmd[k]), .i_eq(meq[k]), .i_neg(mneg[k]),
            .i_a(ma[k]), .i_b(mb[k]), .i_y(my[k]), .i_acc(macc[k]),
            .o_valid(mv[k+1]), .o_cmd(mcmd[k+1]), .o_eq(meq[k+1]), .o_neg(mneg[k+1]),
            .o_a(ma[k+1]), .o_b(mb[k+1]), .o_y(my[k+1]), .o_acc(macc[k+1])
        );
    end

    // command result from reduced operands and product
    always_comb begin
        sum_ab = {1'b0, ma[W]} + {1'b0, mb[W]};
        sum_aa = {1'b0, ma[W]} + {1'b0, ma[W]};
        if (sum_ab >= {1'b0, r_modulus}) sum_ab = sum_ab - {1'b0, r_modulus};
        if (sum_aa >= {1'b0, r_modulus}) sum_aa = sum_aa - {1'b0, r_modulus};
        prod = macc[W];
        case (mcmd[W])
            CMD_ADD:    n_result = sum_ab[W-1:0];
            CMD_SUB:    n_result = (ma[W] >= mb[W]) ? (ma[W] - mb[W])
                                                    : (r_modulus - mb[W] + ma[W]);
            CMD_MUL:    n_result = prod;
            CMD_SQUARE: n_result = prod;
            CMD_NEGATE: n_result = (ma[W] != '0) ? (r_modulus - ma[W]) : '0;
            CMD_DOUBLE: n_result = sum_aa[W-1:0];
            CMD_SMUL:   n_result = (mneg[W] && prod != '0) ? (r_modulus - prod) : prod;
            default:    n_result = '0;
        endcase
        if (r_modulus < W'(2)) n_result = '0;
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= mv[W];
        end
    end

    // output payload and flags
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result  <= n_result;
            r_is_zero <= (n_result == '0);
            r_is_one  <= (n_result == W'(1));
            r_eq      <= meq[W];
            if (n_result == '0)     r_sign <= SIGN_ZERO;
            else if (n_result[0])   r_sign <= SIGN_ODD;
            else                    r_sign <= SIGN_EVEN;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.result         = r_result;
    assign o_out.result_is_zero = r_is_zero;
    assign o_out.result_is_one  = r_is_one;
    assign o_out.result_sign    = r_sign;
    assign o_out.operands_equal = r_eq;

    // result stays below a valid modulus
    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_modulus >= W'(2)) |-> (r_result < r_modulus))
        else $error("result not reduced");

    // zero flag agrees with the sign code
    a_zero_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_is_zero == (r_sign == SIGN_ZERO)))
        else $error("zero flag and sign code disagree");

    // an empty output stage never holds back the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with empty output");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("output valid after reset");
endmodule
